/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL top level of the air-quality block.
// Depends on nothing; users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

/* rtl/core/gbaq_pkg.sv */
// Package for the gas-baseline air-quality block: widths, constants,
// codes and the command/status structs between controller and datapath.
// No dependencies.
package gbaq_pkg;

    localparam int GAS_W         = 24;
    localparam int HUM_W         = 14;
    localparam int END_W         = 16;
    localparam int IAQ_W         = 9;
    localparam int ACC_W         = 2;
    localparam int BASE_INT_BITS = 24;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DIV_STEPS     = 8;
    localparam int Q_W           = 8;
    localparam int HREM_W        = 15;

    localparam logic [GAS_W-1:0] GAS_MIN = 24'd1000;
    localparam logic [GAS_W-1:0] GAS_MAX = 24'd10000000;

    localparam logic [HUM_W-1:0] HUM_TARGET_RST = 14'd4000;
    localparam logic [END_W-1:0] WARMUP_RST     = 16'd50;
    localparam logic [END_W-1:0] CALIBRATE_RST  = 16'd150;
    localparam logic [END_W-1:0] SETTLE_RST     = 16'd300;

    localparam logic [HUM_W-1:0] HUM_DEADBAND = 14'd2000;
    localparam logic [7:0]       HUM_STEP     = 8'd200;
    localparam logic [IAQ_W-1:0] IAQ_MAX      = 9'd500;
    localparam logic [IAQ_W-1:0] IAQ_NO_BASE  = 9'd100;

    localparam logic [ACC_W-1:0] ACC_STABILIZING = 2'd0;
    localparam logic [ACC_W-1:0] ACC_UNCERTAIN   = 2'd1;
    localparam logic [ACC_W-1:0] ACC_CALIBRATING = 2'd2;
    localparam logic [ACC_W-1:0] ACC_CALIBRATED  = 2'd3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HUMIDITY_TARGET = 2'd0,
        CFG_WARMUP_END      = 2'd1,
        CFG_CALIBRATE_END   = 2'd2,
        CFG_SETTLE_END      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [HUM_W-1:0] humidity_target;
        logic [END_W-1:0] warmup_end;
        logic [END_W-1:0] calibrate_end;
        logic [END_W-1:0] settle_end;
    } t_cfg;

    typedef enum logic [2:0] {
        COEF_FAST,
        COEF_MED,
        COEF_SLOW,
        COEF_ADAPT,
        COEF_THR
    } t_coef;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COUNT,
        ST_PLAN,
        ST_MUL,
        ST_CHECK,
        ST_MIX_WB,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             capture;
        logic             count;
        logic             seed;
        logic             set_ready;
        logic             set_acc;
        logic [ACC_W-1:0] acc;
        logic             mul_start;
        t_coef            coef_sel;
        logic             mul_step;
        logic             mix_wb;
        logic             prep;
        logic             div_step;
        logic             fin;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic used;
        logic ready_flag;
        logic lt_warm;
        logic lt_cal;
        logic lt_settle;
        logic base_zero;
        logic adapt_hit;
    } t_sts;

endpackage

/* rtl/core/gbaq_datapath.sv */
// Datapath: baseline state, serial shift-add multiplier, restoring divider
// and index assembly. Driven by gbaq_ctrl; uses gbaq_pkg.
module gbaq_datapath
    import gbaq_pkg::*;
#(
    parameter int BASE_FRAC_BITS = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int COUNT_BITS     = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  t_cfg             i_cfg,
    input  logic [GAS_W-1:0] i_gas_ohms,
    input  logic [HUM_W-1:0] i_humidity_centi,
    output logic [IAQ_W-1:0] o_iaq_index,
    output logic [ACC_W-1:0] o_accuracy_level,
    output logic             o_sample_used,
    output logic             o_baseline_ready,
    output logic [GAS_W-1:0] o_baseline_ohms
);

    localparam int BW = BASE_INT_BITS + BASE_FRAC_BITS;
    localparam int MW = BW + 1;
    localparam int PW = MW + COEF_FRAC_BITS;
    localparam int DW = BW + Q_W;
    localparam int CW = (COUNT_BITS > END_W) ? COUNT_BITS : END_W;

    localparam logic [63:0] C_ONE = 64'd1 << COEF_FRAC_BITS;
    localparam logic [COEF_FRAC_BITS-1:0] W_FAST =
        COEF_FRAC_BITS'((64'd5 * C_ONE + 64'd50) / 64'd100);
    localparam logic [COEF_FRAC_BITS-1:0] W_MED =
        COEF_FRAC_BITS'((64'd2 * C_ONE + 64'd50) / 64'd100);
    localparam logic [COEF_FRAC_BITS-1:0] W_SLOW =
        COEF_FRAC_BITS'((C_ONE + 64'd50) / 64'd100);
    localparam logic [COEF_FRAC_BITS-1:0] W_ADAPT =
        COEF_FRAC_BITS'((C_ONE + 64'd500) / 64'd1000);
    localparam logic [COEF_FRAC_BITS-1:0] T_CLEAN =
        COEF_FRAC_BITS'((64'd9 * C_ONE + 64'd5) / 64'd10);
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (COEF_FRAC_BITS - 1);

    // Baseline state
    logic [BW-1:0]         r_base;
    logic                  r_ready;
    logic [ACC_W-1:0]      r_acc;
    logic [COUNT_BITS-1:0] r_cnt;

    // Captured sample
    logic [GAS_W-1:0] r_gas;
    logic [HUM_W-1:0] r_hum;
    logic             r_used;

    // Multiplier
    logic signed [MW-1:0]       r_mcand;
    logic [COEF_FRAC_BITS-1:0]  r_coef;
    logic signed [PW-1:0]       r_prod;

    // Divider
    logic [DW-1:0]     r_grem;
    logic [DW-1:0]     r_gdvs;
    logic [Q_W-1:0]    r_gq;
    logic [HREM_W-1:0] r_hrem;
    logic [HREM_W-1:0] r_hdvs;
    logic [Q_W-1:0]    r_hq;
    logic [IAQ_W-1:0]  r_index;

    // Result register
    logic [IAQ_W-1:0] r_out_iaq;
    logic [ACC_W-1:0] r_out_acc;
    logic             r_out_used;
    logic             r_out_ready;
    logic [GAS_W-1:0] r_out_base;

    logic [BW-1:0]             w_gfx;
    logic signed [MW-1:0]      w_mcand;
    logic [COEF_FRAC_BITS-1:0] w_coef;
    logic signed [PW-1:0]      w_round;
    logic signed [PW-1:0]      w_delta;
    logic [BW-1:0]             n_base;
    logic [DW-1:0]             w_gnum;
    logic [HUM_W-1:0]          w_hdiff;
    logic [HUM_W-1:0]          w_hexcess;
    logic [7:0]                w_hneg;
    logic [DW-1:0]             w_lhs;
    logic [DW-1:0]             w_rhs;
    logic [IAQ_W:0]            w_total;
    logic [IAQ_W-1:0]          n_index;

    assign w_gfx = {r_gas, {BASE_FRAC_BITS{1'b0}}};

    always_comb begin
        w_mcand = $signed({1'b0, w_gfx}) - $signed({1'b0, r_base});
        w_coef  = W_FAST;
        case (i_cmd.coef_sel)
            COEF_FAST:  w_coef = W_FAST;
            COEF_MED:   w_coef = W_MED;
            COEF_SLOW:  w_coef = W_SLOW;
            COEF_ADAPT: w_coef = W_ADAPT;
            COEF_THR: begin
                w_mcand = $signed({1'b0, r_base});
                w_coef  = T_CLEAN;
            end
            default: w_coef = W_FAST;
        endcase
    end

    // Round the weighted difference and fold it into the baseline
    assign w_round = r_prod + HALF;
    assign w_delta = w_round >>> COEF_FRAC_BITS;
    assign n_base  = r_base + w_delta[BW-1:0];

    always_comb begin
        if (w_gfx >= r_base) begin
            w_gnum = '0;
        end else if ({w_gfx, 1'b0} >= {1'b0, r_base}) begin
            w_gnum = DW'(150) * DW'(r_base - w_gfx);
        end else begin
            w_gnum = DW'(225) * DW'(r_base) - DW'(300) * DW'(w_gfx);
        end
    end

    assign w_hdiff   = (r_hum >= i_cfg.humidity_target) ? r_hum - i_cfg.humidity_target
                                                        : i_cfg.humidity_target - r_hum;
    assign w_hexcess = (w_hdiff > HUM_DEADBAND) ? w_hdiff - HUM_DEADBAND : '0;

    // Round up the summed fractions when they reach a whole point
    assign w_hneg  = 8'(9'(HUM_STEP) - {1'b0, r_hrem[7:0]});
    assign w_lhs   = r_grem * DW'(HUM_STEP);
    assign w_rhs   = DW'(w_hneg) * DW'(r_base);
    assign w_total = (IAQ_W + 1)'(r_gq) + (IAQ_W + 1)'(r_hq)
                   + (IAQ_W + 1)'(w_lhs >= w_rhs);

    always_comb begin
        if (r_base == '0) begin
            n_index = IAQ_NO_BASE;
        end else if (w_total > (IAQ_W + 1)'(IAQ_MAX)) begin
            n_index = IAQ_MAX;
        end else begin
            n_index = w_total[IAQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_ready <= 1'b0;
            r_acc   <= ACC_STABILIZING;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.count && r_used && (r_cnt != {COUNT_BITS{1'b1}})) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.seed) begin
                r_base <= w_gfx;
            end else if (i_cmd.mix_wb) begin
                r_base <= n_base;
            end
            if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
            if (i_cmd.set_acc) begin
                r_acc <= i_cmd.acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_gas  <= i_gas_ohms;
            r_hum  <= i_humidity_centi;
            r_used <= (i_gas_ohms >= GAS_MIN) && (i_gas_ohms <= GAS_MAX);
        end
        if (i_cmd.mul_start) begin
            r_mcand <= w_mcand;
            r_coef  <= w_coef;
            r_prod  <= '0;
        end else if (i_cmd.mul_step) begin
            r_prod <= (r_prod <<< 1)
                    + (r_coef[COEF_FRAC_BITS-1] ? PW'(r_mcand) : PW'(0));
            r_coef <= r_coef << 1;
        end
        if (i_cmd.prep) begin
            r_grem <= w_gnum;
            r_gdvs <= DW'(r_base) << (DIV_STEPS - 1);
            r_gq   <= '0;
            r_hrem <= HREM_W'(w_hexcess);
            r_hdvs <= HREM_W'(HUM_STEP) << (DIV_STEPS - 1);
            r_hq   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_grem >= r_gdvs) begin
                r_grem <= r_grem - r_gdvs;
                r_gq   <= {r_gq[Q_W-2:0], 1'b1};
            end else begin
                r_gq   <= {r_gq[Q_W-2:0], 1'b0};
            end
            if (r_hrem >= r_hdvs) begin
                r_hrem <= r_hrem - r_hdvs;
                r_hq   <= {r_hq[Q_W-2:0], 1'b1};
            end else begin
                r_hq   <= {r_hq[Q_W-2:0], 1'b0};
            end
            r_gdvs <= r_gdvs >> 1;
            r_hdvs <= r_hdvs >> 1;
        end
        if (i_cmd.fin) begin
            r_index <= n_index;
        end
        if (i_cmd.load_out) begin
            r_out_iaq   <= r_index;
            r_out_acc   <= r_acc;
            r_out_used  <= r_used;
            r_out_ready <= r_ready;
            r_out_base  <= r_base[BASE_FRAC_BITS +: GAS_W];
        end
    end

    assign o_sts.used       = r_used;
    assign o_sts.ready_flag = r_ready;
    assign o_sts.lt_warm    = CW'(r_cnt) < CW'(i_cfg.warmup_end);
    assign o_sts.lt_cal     = CW'(r_cnt) < CW'(i_cfg.calibrate_end);
    assign o_sts.lt_settle  = CW'(r_cnt) < CW'(i_cfg.settle_end);
    assign o_sts.base_zero  = (r_base == '0);
    assign o_sts.adapt_hit  = {1'b0, w_gfx} > r_prod[PW-1:COEF_FRAC_BITS];

    assign o_iaq_index      = r_out_iaq;
    assign o_accuracy_level = r_out_acc;
    assign o_sample_used    = r_out_used;
    assign o_baseline_ready = r_out_ready;
    assign o_baseline_ohms  = r_out_base;

endmodule

/* rtl/core/gbaq_ctrl.sv */
// Controller: sequences capture, baseline update, division and result
// hand-off. Commands gbaq_datapath; uses gbaq_pkg.
module gbaq_ctrl
    import gbaq_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int STEP_BITS =
        $clog2((COEF_FRAC_BITS > DIV_STEPS) ? COEF_FRAC_BITS : DIV_STEPS);

    t_state               r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;
    logic                 r_mix, n_mix;
    logic                 r_out_valid, n_out_valid;

    logic w_seed;
    logic w_mix;
    logic w_slot_free;

    // Stage decision, taken on the count after this sample
    assign w_seed = i_sts.used && !i_sts.ready_flag && i_sts.lt_warm && i_sts.base_zero;
    assign w_mix  = i_sts.used && !i_sts.ready_flag
                 && ((i_sts.lt_warm && !i_sts.base_zero)
                  || (!i_sts.lt_warm && (i_sts.lt_cal || i_sts.lt_settle)));
    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_mix   = r_mix;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: n_state = ST_PLAN;
            ST_PLAN: begin
                n_state = ST_PREP;
                n_step  = STEP_BITS'(COEF_FRAC_BITS - 1);
                if (w_mix) begin
                    n_state = ST_MUL;
                    n_mix   = 1'b1;
                end else if (i_sts.used && i_sts.ready_flag) begin
                    n_state = ST_MUL;
                    n_mix   = 1'b0;
                end
            end
            ST_MUL: begin
                if (r_step == '0) begin
                    n_state = r_mix ? ST_MIX_WB : ST_CHECK;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_CHECK: begin
                if (i_sts.adapt_hit) begin
                    n_state = ST_MUL;
                    n_mix   = 1'b1;
                    n_step  = STEP_BITS'(COEF_FRAC_BITS - 1);
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_MIX_WB: n_state = ST_PREP;
            ST_PREP: begin
                n_state = ST_DIV;
                n_step  = STEP_BITS'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                if (r_step == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            ST_FIN: n_state = ST_OUT;
            ST_OUT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == ST_OUT) && w_slot_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.coef_sel = COEF_FAST;
        o_cmd.acc      = ACC_STABILIZING;
        unique case (r_state)
            ST_IDLE:  o_cmd.capture = i_in_valid;
            ST_COUNT: o_cmd.count = 1'b1;
            ST_PLAN: begin
                if (w_seed) begin
                    o_cmd.seed    = 1'b1;
                    o_cmd.set_acc = 1'b1;
                    o_cmd.acc     = ACC_STABILIZING;
                end else if (w_mix) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.set_acc   = 1'b1;
                    if (i_sts.lt_warm) begin
                        o_cmd.coef_sel = COEF_FAST;
                        o_cmd.acc      = ACC_STABILIZING;
                    end else if (i_sts.lt_cal) begin
                        o_cmd.coef_sel = COEF_MED;
                        o_cmd.acc      = ACC_UNCERTAIN;
                    end else begin
                        o_cmd.coef_sel = COEF_SLOW;
                        o_cmd.acc      = ACC_CALIBRATING;
                    end
                end else if (i_sts.used && !i_sts.ready_flag) begin
                    o_cmd.set_ready = 1'b1;
                    o_cmd.set_acc   = 1'b1;
                    o_cmd.acc       = ACC_CALIBRATED;
                end else if (i_sts.used) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.coef_sel  = COEF_THR;
                end
            end
            ST_MUL: o_cmd.mul_step = 1'b1;
            ST_CHECK: begin
                if (i_sts.adapt_hit) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.coef_sel  = COEF_ADAPT;
                end
            end
            ST_MIX_WB: o_cmd.mix_wb   = 1'b1;
            ST_PREP:   o_cmd.prep     = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FIN:    o_cmd.fin      = 1'b1;
            ST_OUT:    o_cmd.load_out = w_slot_free;
            default:   o_cmd.capture  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_mix       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_mix       <= n_mix;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/core/gas_baseline_air_quality_index.sv */
// Top level of the gas-baseline air-quality block: configuration registers,
// controller and datapath. Uses gbaq_pkg, gbaq_ctrl, gbaq_datapath.
//
// Each input beat carries one gas-resistance and one humidity sample and
// yields exactly one result beat. Resistances outside 1000..10000000 ohms are
// flagged as unused and leave the baseline alone, but still get an index. A
// used sample bumps a saturating count and moves the gas baseline: the first
// seeds it, then it is mixed with weight 0.05 until the count reaches
// warmup_end, 0.02 until calibrate_end and 0.01 until settle_end; at
// settle_end the baseline is marked ready and from then on only readings
// above 0.9 of it pull it, with weight 0.001. The index is a gas-ratio score
// plus a humidity penalty, 0..500, or 100 while the baseline is still zero.
// One item is worked at a time; the next beat is taken while the finished
// result waits in the output register. An item passes through count and
// plan, a multiply if a weighted update or threshold check is due (and a
// second one for the slow update when the threshold passes), the divide,
// the index and the output load. The work is done by the single shift-add
// multiplier, one coefficient bit a cycle, and by the eight-step restoring
// divider that forms the gas score and the humidity penalty. Configuration
// writes take effect at once and are meant for idle periods only.
`include "assert_macros.svh"

module gas_baseline_air_quality_index
    import gbaq_pkg::*;
#(
    parameter int BASE_FRAC_BITS = 16,
    parameter int COEF_FRAC_BITS = 16,
    parameter int COUNT_BITS     = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [GAS_W-1:0]      i_gas_ohms,
    input  logic [HUM_W-1:0]      i_humidity_centi,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IAQ_W-1:0]      o_iaq_index,
    output logic [ACC_W-1:0]      o_accuracy_level,
    output logic                  o_sample_used,
    output logic                  o_baseline_ready,
    output logic [GAS_W-1:0]      o_baseline_ohms
);

    t_cfg r_cfg;
    t_cmd s_cmd;
    t_sts s_sts;

    // Configuration registers; drop bits above each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.humidity_target <= HUM_TARGET_RST;
            r_cfg.warmup_end      <= WARMUP_RST;
            r_cfg.calibrate_end   <= CALIBRATE_RST;
            r_cfg.settle_end      <= SETTLE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_HUMIDITY_TARGET: r_cfg.humidity_target <= i_cfg_wdata[HUM_W-1:0];
                CFG_WARMUP_END:      r_cfg.warmup_end      <= i_cfg_wdata[END_W-1:0];
                CFG_CALIBRATE_END:   r_cfg.calibrate_end   <= i_cfg_wdata[END_W-1:0];
                CFG_SETTLE_END:      r_cfg.settle_end      <= i_cfg_wdata[END_W-1:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Sequencer: one state per phase, step counter for the serial units
    gbaq_ctrl #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    // Baseline state, multiplier, divider and result register
    gbaq_datapath #(
        .BASE_FRAC_BITS (BASE_FRAC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .o_sts            (s_sts),
        .i_cfg            (r_cfg),
        .i_gas_ohms       (i_gas_ohms),
        .i_humidity_centi (i_humidity_centi),
        .o_iaq_index      (o_iaq_index),
        .o_accuracy_level (o_accuracy_level),
        .o_sample_used    (o_sample_used),
        .o_baseline_ready (o_baseline_ready),
        .o_baseline_ohms  (o_baseline_ohms)
    );

    // One item in flight: an accepted beat closes the input side
    `ASSERT_NEXT(a_single_item, i_in_valid && o_in_ready, !o_in_ready, "second beat taken while busy")
    // A loaded result is presented on the next cycle
    `ASSERT_NEXT(a_load_shows, s_cmd.load_out, o_out_valid, "loaded result not presented")
    // A ready baseline always reports full accuracy
    `ASSERT_IMPL(a_ready_acc, o_out_valid && o_baseline_ready, o_accuracy_level == ACC_CALIBRATED, "ready baseline without full accuracy")
    // Index never leaves its range
    `ASSERT_IMPL(a_iaq_range, o_out_valid && o_sample_used, o_iaq_index <= IAQ_MAX, "index above range")

endmodule

/* test/tb_gas_baseline_air_quality_index.sv */
// Self-checking bench for gas_baseline_air_quality_index: staged baseline averaging,
// threshold tracking once ready, and the gas/humidity index on every sample beat.
// Depends on gbaq_pkg and the RTL top level only.
module tb_gas_baseline_air_quality_index;
    timeunit 1ns;
    timeprecision 1ps;

    import gbaq_pkg::*;

    localparam int BASE_FRAC_BITS = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COUNT_BITS     = 16;

    localparam int     CLK_HALF      = 5;
    localparam int     RST_CYCLES    = 7;
    localparam int     IDLE_PCT      = 11;
    localparam int     REST_CYCLES   = 64;          // longer than the longest item
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_SAMPLES = 237;
    localparam int     MAX_REPORTS   = 10;
    localparam longint RUN_LIMIT_NS  = 20_000_000;  // far beyond the slowest clean run

    // Averaging weights and the tracking threshold as coefficient fractions.
    localparam bit [63:0] Q_ONE       = 64'd1 << COEF_FRAC_BITS;
    localparam bit [63:0] WT_WARMUP   = (5 * Q_ONE + 50) / 100;
    localparam bit [63:0] WT_CALIB    = (2 * Q_ONE + 50) / 100;
    localparam bit [63:0] WT_SETTLE   = (Q_ONE + 50) / 100;
    localparam bit [63:0] WT_TRACK    = (Q_ONE + 500) / 1000;
    localparam bit [63:0] CLEAN_FLOOR = (9 * Q_ONE + 5) / 10;

    typedef struct packed {
        logic [GAS_W-1:0] gas;
        logic [HUM_W-1:0] hum;
    } t_gas_sample;

    typedef struct packed {
        logic [IAQ_W-1:0] iaq;
        logic [ACC_W-1:0] acc;
        logic             used;
        logic             ready;
        logic [GAS_W-1:0] base;
    } t_aq_result;

    // Stimulus and DUT wiring; every input starts at a known value.
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata      = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [GAS_W-1:0]      i_gas_ohms       = '0;
    logic [HUM_W-1:0]      i_humidity_centi = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [IAQ_W-1:0]      o_iaq_index;
    logic [ACC_W-1:0]      o_accuracy_level;
    logic                  o_sample_used;
    logic                  o_baseline_ready;
    logic [GAS_W-1:0]      o_baseline_ohms;

    // Predictor state and its mirror of the configuration registers.
    bit [63:0]             air_base     = '0;
    bit                    base_ready   = 1'b0;
    logic [ACC_W-1:0]      acc_now      = ACC_STABILIZING;
    bit [COUNT_BITS-1:0]   used_count   = '0;
    logic [HUM_W-1:0]      tgt_humidity = HUM_TARGET_RST;
    logic [END_W-1:0]      end_warmup   = WARMUP_RST;
    logic [END_W-1:0]      end_calib    = CALIBRATE_RST;
    logic [END_W-1:0]      end_settle   = SETTLE_RST;

    t_gas_sample samples_pending[$];
    t_aq_result  iaq_due[$];
    bit          sample_taken = 1'b0;
    bit          no_gaps      = 1'b0;
    int          faults       = 0;
    int          beats_out    = 0;

    gas_baseline_air_quality_index #(
        .BASE_FRAC_BITS (BASE_FRAC_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COUNT_BITS     (COUNT_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_gas_ohms       (i_gas_ohms),
        .i_humidity_centi (i_humidity_centi),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_iaq_index      (o_iaq_index),
        .o_accuracy_level (o_accuracy_level),
        .o_sample_used    (o_sample_used),
        .o_baseline_ready (o_baseline_ready),
        .o_baseline_ohms  (o_baseline_ohms)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Weighted moving average step, rounded to nearest at coefficient scale.
    function automatic bit [63:0] blend(bit [63:0] old, bit [63:0] g, bit [63:0] w);
        return (old * (Q_ONE - w) + g * w + (Q_ONE >> 1)) >> COEF_FRAC_BITS;
    endfunction

    // Gas-ratio score plus humidity penalty, evaluated exactly in integers:
    // the fractional parts of both terms are combined before truncation.
    function automatic logic [IAQ_W-1:0] air_index(bit [63:0] gfx, logic [HUM_W-1:0] hum);
        bit [63:0] b, gnum, gi, gr, dev, excess, hi, hr, total;
        b = air_base;
        if (b == 0)
            return IAQ_NO_BASE;
        if (gfx >= b)
            gnum = 0;
        else if (2 * gfx >= b)
            gnum = 150 * (b - gfx);
        else
            gnum = 225 * b - 300 * gfx;
        gi = gnum / b;
        gr = gnum % b;
        dev = (hum >= tgt_humidity) ? 64'(hum) - 64'(tgt_humidity)
                                    : 64'(tgt_humidity) - 64'(hum);
        excess = (dev > 64'(HUM_DEADBAND)) ? dev - 64'(HUM_DEADBAND) : 64'd0;
        hi = excess / 64'(HUM_STEP);
        hr = excess % 64'(HUM_STEP);
        total = gi + hi;
        if (200 * gr >= (200 - hr) * b)
            total = total + 1;
        return (total > 64'(IAQ_MAX)) ? IAQ_MAX : total[IAQ_W-1:0];
    endfunction

    // Advance the predicted state by one sample and queue the result it yields.
    task automatic absorb_sample(input logic [GAS_W-1:0] gas, input logic [HUM_W-1:0] hum);
        bit [63:0]  gfx;
        bit         usable;
        t_aq_result r;
        gfx = 64'(gas) << BASE_FRAC_BITS;
        usable = (gas >= GAS_MIN) && (gas <= GAS_MAX);
        if (usable) begin
            if (used_count != '1)
                used_count = used_count + 1'b1;
            if (!base_ready) begin
                if (used_count < end_warmup) begin
                    air_base = (air_base == 0) ? gfx : blend(air_base, gfx, WT_WARMUP);
                    acc_now = ACC_STABILIZING;
                end else if (used_count < end_calib) begin
                    air_base = blend(air_base, gfx, WT_CALIB);
                    acc_now = ACC_UNCERTAIN;
                end else if (used_count < end_settle) begin
                    air_base = blend(air_base, gfx, WT_SETTLE);
                    acc_now = ACC_CALIBRATING;
                end else begin
                    base_ready = 1'b1;
                    acc_now = ACC_CALIBRATED;
                end
            end else if (gfx > ((air_base * CLEAN_FLOOR) >> COEF_FRAC_BITS)) begin
                air_base = blend(air_base, gfx, WT_TRACK);
            end
        end
        r.iaq   = air_index(gfx, hum);
        r.acc   = acc_now;
        r.used  = usable;
        r.ready = base_ready;
        r.base  = air_base[BASE_FRAC_BITS +: GAS_W];
        iaq_due.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Sample channel: note accepted beats at the rising edge, drive at the
    // falling edge. Hold valid and payload until the beat is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            absorb_sample(i_gas_ohms, i_humidity_centi);
            sample_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin : feed
        t_gas_sample nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (sample_taken || !i_in_valid) begin
            sample_taken = 1'b0;
            // Idle only between beats, never with a beat on offer.
            if (samples_pending.size() != 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PCT)) begin
                nxt = samples_pending.pop_front();
                i_in_valid       <= 1'b1;
                i_gas_ohms       <= nxt.gas;
                i_humidity_centi <= nxt.hum;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result channel: random back-pressure, check every accepted beat
    // against the oldest predicted result.
    // ------------------------------------------------------------------
    task automatic report_fault(input string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_out
        t_aq_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_out++;
            if (iaq_due.size() == 0) begin
                report_fault($sformatf("result beat %0d arrived with nothing predicted",
                                       beats_out));
            end else begin
                want = iaq_due.pop_front();
                if (o_iaq_index !== want.iaq || o_accuracy_level !== want.acc ||
                    o_sample_used !== want.used || o_baseline_ready !== want.ready ||
                    o_baseline_ohms !== want.base)
                    report_fault($sformatf({"result beat %0d: expected iaq %0d acc %0d ",
                        "used %0b ready %0b base %0d, got iaq %0d acc %0d used %0b ",
                        "ready %0b base %0d"}, beats_out,
                        want.iaq, want.acc, want.used, want.ready, want.base,
                        o_iaq_index, o_accuracy_level, o_sample_used,
                        o_baseline_ready, o_baseline_ohms));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_sample(longint gas, int hum);
        t_gas_sample s;
        s.gas = (gas < 0) ? '0 : (gas > longint'(2**GAS_W - 1)) ? '1 : GAS_W'(gas);
        s.hum = (hum < 0) ? '0 : (hum > 2**HUM_W - 1) ? '1 : HUM_W'(hum);
        samples_pending.push_back(s);
    endfunction

    // Register write at a falling edge; the mirror follows at once since the
    // block is idle whenever this runs.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HUMIDITY_TARGET: tgt_humidity = data[HUM_W-1:0];
            CFG_WARMUP_END:      end_warmup   = data[END_W-1:0];
            CFG_CALIBRATE_END:   end_calib    = data[END_W-1:0];
            CFG_SETTLE_END:      end_settle   = data[END_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] hum, input logic [END_W-1:0] w,
                             input logic [END_W-1:0] c, input logic [END_W-1:0] s);
        write_reg(CFG_HUMIDITY_TARGET, hum);
        write_reg(CFG_WARMUP_END, w);
        write_reg(CFG_CALIBRATE_END, c);
        write_reg(CFG_SETTLE_END, s);
    endtask

    // Humidity target with junk in the bits above the register width.
    function automatic logic [CFG_DATA_W-1:0] any_humidity();
        logic [HUM_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = 14'd10000;
            2:       v = '1;
            3:       v = HUM_TARGET_RST;
            default: v = HUM_W'($urandom_range(0, 10000));
        endcase
        return {2'($urandom), v};
    endfunction

    function automatic logic [END_W-1:0] any_end();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'd1;
            2:       return '1;
            default: return END_W'($urandom);
        endcase
    endfunction

    // Stage boundaries ahead of the current count while the baseline is still
    // forming, so each phase walks through the remaining stages; register
    // extremes or random values once it is ready, and fixed extremes on the last two phases.
    task automatic configure_phase(input int p);
        logic [END_W-1:0] w, c, s;
        if (p == RANDOM_PHASES - 1) begin
            write_all(16'hFFFF, '1, '1, '1);
        end else if (p == RANDOM_PHASES - 2) begin
            write_all(16'h0000, '0, '0, '0);
        end else begin
            if (!base_ready) begin
                w = END_W'(int'(used_count) + $urandom_range(0, 30));
                c = END_W'(int'(w) + $urandom_range(0, 60));
                s = END_W'(int'(c) + $urandom_range(0, 120));
            end else begin
                w = any_end();
                c = any_end();
                s = any_end();
            end
            write_all(any_humidity(), w, c, s);
        end
    endtask

    // Mostly in-range resistances around the current baseline so that all
    // three score bands and both sides of the tracking threshold come up;
    // the rest are rejects, raw 24-bit noise and uniform in-range values.
    task automatic queue_random_samples(input int n);
        longint ref_ohms, g;
        int     hum, sel;
        ref_ohms = longint'(air_base >> BASE_FRAC_BITS);
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                g = $urandom_range(0, 999);
            else if (sel < 10)
                g = $urandom_range(10000001, 2**GAS_W - 1);
            else if (sel < 18)
                g = longint'($urandom) & (2**GAS_W - 1);
            else if (sel < 28 || ref_ohms < 1000)
                g = $urandom_range(1000, 10000000);
            else begin
                g = ref_ohms * $urandom_range(20, 160) / 100 + $urandom_range(0, 99);
                g = (g < 1000) ? 1000 : (g > 10000000) ? 10000000 : g;
            end
            if ($urandom_range(0, 99) < 8)
                hum = $urandom_range(0, 2**HUM_W - 1);
            else
                hum = int'(tgt_humidity) + $urandom_range(0, 14000) - 7000;
            push_sample(g, hum);
        end
    endtask

    // Wait until every beat is sent and every result is back, then let the
    // block go quiet before anything else touches it.
    task automatic drain_and_rest();
        while (samples_pending.size() != 0 || i_in_valid || iaq_due.size() != 0)
            @(posedge i_clk);
        repeat (REST_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int               mode, t;
        longint           b;
        logic [END_W-1:0] w, c, s;

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers, zero baseline: rejects at both range edges and
        // humidity extremes all report the no-baseline index.
        push_sample(0, 0);
        push_sample(999, 10000);
        push_sample(10000001, 2**HUM_W - 1);
        push_sample(2**GAS_W - 1, 4000);
        drain_and_rest();

        // The first used sample either seeds the baseline or, with small
        // stage boundaries, is mixed into a zero baseline by a later stage
        // (or even marks it ready while still zero). Pick one per run.
        mode = $urandom_range(0, 2);
        case (mode)
            0: begin
                w = END_W'($urandom_range(2, 40));
                c = END_W'(int'(w) + $urandom_range(0, 80));
                s = END_W'(int'(c) + $urandom_range(0, 150));
            end
            1: begin
                w = END_W'($urandom_range(0, 1));
                c = END_W'($urandom_range(2, 60));
                s = END_W'(int'(c) + $urandom_range(0, 150));
            end
            default: begin
                w = END_W'($urandom_range(0, 1));
                c = END_W'($urandom_range(0, 1));
                s = END_W'($urandom_range(0, 150));
            end
        endcase
        write_all(any_humidity(), w, c, s);

        // Range edges once the baseline is live.
        push_sample(1000, 0);
        push_sample(10000000, 10000);
        push_sample(1000, 2**HUM_W - 1);
        push_sample(500000, tgt_humidity);
        drain_and_rest();

        // Score band edges around the baseline and the humidity dead band.
        b = longint'(air_base >> BASE_FRAC_BITS);
        if (b == 0)
            b = 100000;
        t = tgt_humidity;
        push_sample(b, t);
        push_sample(b + 1, t + 2000);
        push_sample(b / 2, t - 2001);
        push_sample(b / 2 + 1, t + 2200);
        push_sample(b / 4, t + 2199);
        push_sample(0, t);
        push_sample(2**GAS_W - 1, 2**HUM_W - 1);
        push_sample(2 * b, 0);
        push_sample(b * 9 / 10, 10000);
        push_sample(b * 95 / 100, t - 4000);
        drain_and_rest();

        // Random phases, one of them without any idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            configure_phase(p);
            no_gaps = (p == 3);
            queue_random_samples(PHASE_SAMPLES);
            drain_and_rest();
        end

        if (faults == 0 && iaq_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
